// ===== hw/rtl/tbsl_pkg.sv =====
// Shared types and constants of the tag block store.
// Depends on nothing; the other RTL files, tbsl_ram apart, refer to it by scoped names.
`default_nettype none

package tbsl_pkg;

  localparam int NUM_BLOCKS  = 64;
  localparam int MAX_RESULTS = 64;
  localparam int ADDR_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W       = 9;
  localparam int DATA_W      = 32;
  localparam int ENTRY_W     = DATA_W + 2;

  localparam logic [CNT_W-1:0] NUM_BLOCKS_C  = CNT_W'(NUM_BLOCKS);
  localparam logic [CNT_W-1:0] MAX_RESULTS_C = CNT_W'(MAX_RESULTS);

  localparam logic [1:0] LOCK_USER    = 2'b01;
  localparam logic [1:0] LOCK_FACTORY = 2'b10;

  localparam logic [2:0] OP_READ_SINGLE  = 3'd0;
  localparam logic [2:0] OP_WRITE_SINGLE = 3'd1;
  localparam logic [2:0] OP_LOCK_BLOCK   = 3'd2;
  localparam logic [2:0] OP_READ_MULTI   = 3'd3;
  localparam logic [2:0] OP_SEC_STATUS   = 3'd4;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [7:0]        block_address;
    logic [7:0]        count_minus_one;
    logic [DATA_W-1:0] write_word;
    logic              option_flag;
    logic              addressed_flag;
    logic              length_ok;
  } cmd_item_t;

  typedef struct packed {
    logic              error_flag;
    logic [7:0]        lock_byte;
    logic              lock_valid;
    logic [DATA_W-1:0] block_word;
    logic              data_valid;
    logic              last;
  } rsp_item_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch the command being transferred
    logic load_err;  // load generic error response
    logic rd;        // read entry at current block
    logic load_res;  // format response from read entry
    logic wr;        // write entry at current block
    logic advance;   // step to next block
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       acc_drop;  // incoming command gives no response and no update, unless acc_err is set
    logic       acc_err;   // incoming command gives an error response
    logic [2:0] op;        // latched opcode
    logic       unlocked;  // read entry has both lock bits clear
    logic       more;      // blocks remain after the current one
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tag_block_store_with_locks.sv =====
// Block memory of a vicinity tag with per-block user and factory locks. It takes
// one parsed command per transfer on cmd and returns zero or more response items
// on rsp, the final one marked by last. A command that touches a block takes one
// entry access: it is captured, its block is read from the RAM (registered
// read), then checked and formatted, and the response item is offered until it
// is taken. Read multiple and security status repeat read, format and offer for
// each block. An addressed read with a start block past the end is answered
// with the error item from the cycle after the transfer. Writes and lock
// commands update the RAM in the format cycle; a lock or a refused write holds
// cmd_ready low through the read and check states, while a dropped command
// leaves cmd_ready high. The block takes one command at a time: cmd_ready is
// high only while no command is in progress.
// Data and lock bits share one RAM entry per block; a valid bit per entry, cleared
// by reset, makes every block read as zero data and unlocked until written, so
// no clearing pass is needed after reset.
// Depends on tbsl_pkg, tbsl_ctrl, tbsl_dp (which holds tbsl_ram).
`default_nettype none

module tag_block_store_with_locks (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // command channel
  input  wire logic                 cmd_valid,
  output logic                      cmd_ready,
  input  wire tbsl_pkg::cmd_item_t  cmd,
  // response channel
  output logic                      rsp_valid,
  input  wire logic                 rsp_ready,
  output tbsl_pkg::rsp_item_t       rsp
);

  tbsl_pkg::dp_cmd_t    ctl;
  tbsl_pkg::dp_status_t status;

  // sequencing: capture, read, format, offer
  tbsl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .status    (status),
    .ctl       (ctl)
  );

  // command registers, block RAM and response register
  tbsl_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .ctl    (ctl),
    .status (status),
    .rsp    (rsp)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/tbsl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module tbsl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tbsl_ctrl.sv =====
// Sequencing state machine of the tag block store.
// Depends on tbsl_pkg; drives the datapath through dp_cmd_t.
`default_nettype none

module tbsl_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cmd_valid,
  output logic                       cmd_ready,
  output logic                       rsp_valid,
  input  wire logic                  rsp_ready,
  input  wire tbsl_pkg::dp_status_t  status,
  output tbsl_pkg::dp_cmd_t          ctl
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       multi;

  assign multi = (status.op == tbsl_pkg::OP_READ_MULTI) ||
                 (status.op == tbsl_pkg::OP_SEC_STATUS);

  always_comb begin
    state_next = state;
    ctl        = '0;
    cmd_ready  = 1'b0;
    rsp_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          ctl.capture = 1'b1;
          if (status.acc_err) begin
            ctl.load_err = 1'b1;
            state_next   = S_OUT;
          end else if (!status.acc_drop) begin
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        ctl.rd     = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        state_next = S_IDLE;
        case (status.op)
          tbsl_pkg::OP_READ_SINGLE,
          tbsl_pkg::OP_READ_MULTI,
          tbsl_pkg::OP_SEC_STATUS: begin
            ctl.load_res = 1'b1;
            state_next   = S_OUT;
          end
          tbsl_pkg::OP_WRITE_SINGLE: begin
            if (status.unlocked) begin
              ctl.wr       = 1'b1;
              ctl.load_res = 1'b1;
              state_next   = S_OUT;
            end
          end
          tbsl_pkg::OP_LOCK_BLOCK: begin
            ctl.wr = status.unlocked;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_OUT: begin
        rsp_valid = 1'b1;
        if (rsp_ready) begin
          if (multi && status.more) begin
            ctl.advance = 1'b1;
            state_next  = S_READ;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tbsl_dp.sv =====
// Datapath of the tag block store: command registers, block RAM with
// per-entry valid bits, and the response register. Depends on tbsl_pkg, tbsl_ram.
`default_nettype none

module tbsl_dp (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire tbsl_pkg::cmd_item_t  cmd,
  input  wire tbsl_pkg::dp_cmd_t    ctl,
  output tbsl_pkg::dp_status_t      status,
  output tbsl_pkg::rsp_item_t       rsp
);

  // latched command
  logic [2:0]                    op;
  logic [tbsl_pkg::ADDR_W-1:0]   cur_addr;
  logic [tbsl_pkg::CNT_W-1:0]    remaining;
  logic [tbsl_pkg::DATA_W-1:0]   word;
  logic                          opt;

  // entry valid bits; an entry never written reads as zero
  logic [tbsl_pkg::NUM_BLOCKS-1:0] valid;
  logic                            rd_valid;
  logic [tbsl_pkg::ENTRY_W-1:0]    ram_q;
  logic [tbsl_pkg::ENTRY_W-1:0]    entry;
  logic [tbsl_pkg::ENTRY_W-1:0]    wr_entry;
  logic [1:0]                      locks;
  logic [tbsl_pkg::DATA_W-1:0]     data;
  logic [7:0]                      lock_code;

  // incoming command decode
  logic                          in_range;
  logic                          op_ok;
  logic [tbsl_pkg::CNT_W-1:0]    room;
  logic [tbsl_pkg::CNT_W-1:0]    req_cnt;
  logic [tbsl_pkg::CNT_W-1:0]    clip_room;
  logic [tbsl_pkg::CNT_W-1:0]    rem_init;
  logic                          is_last;

  tbsl_pkg::rsp_item_t           rsp_next;

  assign in_range  = {1'b0, cmd.block_address} < tbsl_pkg::NUM_BLOCKS_C;
  assign op_ok     = cmd.opcode <= tbsl_pkg::OP_SEC_STATUS;
  assign room      = tbsl_pkg::NUM_BLOCKS_C - {1'b0, cmd.block_address};
  assign req_cnt   = {1'b0, cmd.count_minus_one} + 9'd1;
  assign clip_room = (req_cnt > room) ? room : req_cnt;
  assign rem_init  = !in_range ? 9'd1 :
                     (clip_room > tbsl_pkg::MAX_RESULTS_C) ? tbsl_pkg::MAX_RESULTS_C
                                                           : clip_room;

  assign status.acc_err  = cmd.length_ok && !in_range && cmd.addressed_flag &&
                           ((cmd.opcode == tbsl_pkg::OP_READ_SINGLE) ||
                            (cmd.opcode == tbsl_pkg::OP_READ_MULTI));
  assign status.acc_drop = !cmd.length_ok || !op_ok || !in_range;
  assign status.op       = op;
  assign status.unlocked = (locks == 2'b00);
  assign status.more     = remaining > 9'd1;

  assign entry    = rd_valid ? ram_q : '0;
  assign locks    = entry[tbsl_pkg::ENTRY_W-1 -: 2];
  assign data     = entry[tbsl_pkg::DATA_W-1:0];
  assign is_last  = (remaining == 9'd1);
  assign wr_entry = (op == tbsl_pkg::OP_WRITE_SINGLE) ? {2'b00, word}
                                                      : {tbsl_pkg::LOCK_USER, data};

  // read single reports the strongest lock
  assign lock_code = ((locks & tbsl_pkg::LOCK_FACTORY) != 2'b00) ? {6'b0, tbsl_pkg::LOCK_FACTORY} :
                     ((locks & tbsl_pkg::LOCK_USER) != 2'b00)    ? {6'b0, tbsl_pkg::LOCK_USER}
                                                                 : 8'h00;

  tbsl_ram #(
    .WIDTH (tbsl_pkg::ENTRY_W),
    .DEPTH (tbsl_pkg::NUM_BLOCKS)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.wr),
    .waddr (cur_addr),
    .wdata (wr_entry),
    .re    (ctl.rd),
    .raddr (cur_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctl.wr) begin
      valid[cur_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rd_valid <= valid[cur_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      op        <= cmd.opcode;
      cur_addr  <= cmd.block_address[tbsl_pkg::ADDR_W-1:0];
      remaining <= rem_init;
      word      <= cmd.write_word;
      opt       <= cmd.option_flag;
    end else if (ctl.advance) begin
      cur_addr  <= cur_addr + 1'b1;
      remaining <= remaining - 9'd1;
    end
  end

  always_comb begin
    rsp_next = rsp;
    if (ctl.load_err) begin
      rsp_next            = '0;
      rsp_next.error_flag = 1'b1;
      rsp_next.last       = 1'b1;
    end else if (ctl.load_res) begin
      rsp_next = '0;
      case (op)
        tbsl_pkg::OP_READ_SINGLE: begin
          rsp_next.lock_byte  = opt ? lock_code : 8'h00;
          rsp_next.lock_valid = opt;
          rsp_next.block_word = data;
          rsp_next.data_valid = 1'b1;
          rsp_next.last       = 1'b1;
        end
        tbsl_pkg::OP_READ_MULTI: begin
          rsp_next.lock_byte  = opt ? {6'b0, locks} : 8'h00;
          rsp_next.lock_valid = opt;
          rsp_next.block_word = data;
          rsp_next.data_valid = 1'b1;
          rsp_next.last       = is_last;
        end
        tbsl_pkg::OP_SEC_STATUS: begin
          rsp_next.lock_byte  = {6'b0, locks};
          rsp_next.lock_valid = 1'b1;
          rsp_next.last       = is_last;
        end
        default: begin
          // write acknowledge
          rsp_next.last = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

endmodule

`default_nettype wire
